### rtl/sws_pkg.sv
package sws_pkg;

  // Width of the sequence and ACK fields on the channels.
  localparam int SEQ_W = 16;
  // Register fields.
  localparam int WIN_REG_W = 7;
  localparam int SHIFT_W   = 3;
  localparam int DUP_W     = 3;
  localparam int RTO_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [RTO_W-1:0] RTO_RESET  = 32'd1000000;
  localparam logic [RTO_W-1:0] SRTT_RESET = 32'd1000;
  localparam logic [RTO_W-1:0] DEV_RESET  = 32'd1;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_ACK  = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_SEND_NEW = 3'd1,
    ACT_FAST_RTX = 3'd2,
    ACT_TMO_RTX  = 3'd3,
    ACT_ACKED    = 3'd4,
    ACT_COMPLETE = 3'd5,
    ACT_REJECTED = 3'd6
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE   = 3'd0,
    REG_TOTAL_PACKETS = 3'd1,
    REG_INITIAL_RTO   = 3'd2,
    REG_ALPHA_SHIFT   = 3'd3,
    REG_BETA_SHIFT    = 3'd4,
    REG_DUP_THRESHOLD = 3'd5
  } cfg_reg_e;

  // Updated RTT estimate produced from one sample.
  typedef struct packed {
    logic [RTO_W-1:0] srtt;
    logic [RTO_W-1:0] dev;
    logic [RTO_W-1:0] rto;
  } rtt_est_t;

endpackage

### rtl/sws_ifs.sv
interface sws_event_if;
  import sws_pkg::*;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [SEQ_W-1:0] ack_value;

  modport source (output valid, output opcode, output ack_value, input ready);
  modport sink   (input valid, input opcode, input ack_value, output ready);
endinterface

interface sws_result_if;
  import sws_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       action;
  logic [SEQ_W-1:0] seq_num;
  logic [SEQ_W-1:0] acked_count;
  logic [RTO_W-1:0] timeout_value;

  modport source (output valid, output action, output seq_num, output acked_count,
                  output timeout_value, input ready);
  modport sink   (input valid, input action, input seq_num, input acked_count,
                  input timeout_value, output ready);
endinterface

### rtl/sws_rtt_est.sv
module sws_rtt_est (
  input  logic [sws_pkg::RTO_W-1:0]   srtt,
  input  logic [sws_pkg::RTO_W-1:0]   dev,
  input  logic [sws_pkg::RTO_W-1:0]   sample,
  input  logic [sws_pkg::SHIFT_W-1:0] alpha_shift,
  input  logic [sws_pkg::SHIFT_W-1:0] beta_shift,
  output sws_pkg::rtt_est_t           est
);
  import sws_pkg::*;

  logic [RTO_W-1:0] srtt_new;
  logic [RTO_W-1:0] diff;
  logic [RTO_W-1:0] dev_new;
  logic [RTO_W+2:0] rto_sum;

  // old - old/2^s + sample/2^s never exceeds the 32-bit range
  always_comb begin
    srtt_new = srtt - (srtt >> alpha_shift) + (sample >> alpha_shift);
    diff     = (sample >= srtt_new) ? (sample - srtt_new) : (srtt_new - sample);
    dev_new  = dev - (dev >> beta_shift) + (diff >> beta_shift);
    rto_sum  = {3'b000, srtt_new} + {1'b0, dev_new, 2'b00};
    est.srtt = srtt_new;
    est.dev  = dev_new;
    est.rto  = (rto_sum[RTO_W+2:RTO_W] != 3'b000) ? '1 : rto_sum[RTO_W-1:0];
  end

endmodule

### rtl/sliding_window_sender_with_rto.sv
// An accepted beat is held in the input stage, processed as it advances, and its result
// beat is presented from the result register until taken.
// Throughput: one event beat per cycle, with results drained every cycle.
// Reset (rst, synchronous, active high) restores all window, timer and RTT
// state and the register defaults; the sent-time memory is not cleared.
module sliding_window_sender_with_rto #(
  parameter int MAX_WINDOW = 64,
  parameter int TIME_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sws_pkg::CFG_DATA_W-1:0] cfg_data,
  sws_event_if.sink                      events,
  sws_result_if.source                   results
);
  import sws_pkg::*;

  localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
  localparam int MEM_AW    = $clog2(MAX_WINDOW);
  localparam int MEM_DEPTH = 1 << MEM_AW;
  localparam int SQ_W      = SEQ_W + 1;  // next_seq may reach 2^SEQ_W
  localparam int LIM_W     = SEQ_W + 2;

  // ---------------------------------------------------------------------------
  // Configuration registers. initial_rto only loads rto, so it keeps no copy.
  // ---------------------------------------------------------------------------
  logic [WIN_REG_W-1:0] window_size;
  logic [SEQ_W-1:0]     total_packets;
  logic [SHIFT_W-1:0]   alpha_shift;
  logic [SHIFT_W-1:0]   beta_shift;
  logic [DUP_W-1:0]     dup_threshold;

  // ---------------------------------------------------------------------------
  // Protocol state
  // ---------------------------------------------------------------------------
  logic [SQ_W-1:0]      send_base, send_base_next;
  logic [SQ_W-1:0]      next_seq, next_seq_next;
  logic [DUP_W-1:0]     dup_count, dup_count_next;
  logic [RTO_W-1:0]     smoothed_rtt, smoothed_rtt_next;
  logic [RTO_W-1:0]     rtt_deviation, rtt_deviation_next;
  logic [RTO_W-1:0]     rto, rto_next;
  logic [RTO_W-1:0]     timer_left, timer_left_next;
  logic                 timer_on, timer_on_next;
  logic [TIME_BITS-1:0] now_ticks, now_ticks_next;
  logic                 finished, finished_next;

  // ---------------------------------------------------------------------------
  // Input stage: one event beat held while the result register is busy.
  // ---------------------------------------------------------------------------
  logic             s1_valid;
  opcode_e          s1_opcode;
  logic [SEQ_W-1:0] s1_ack;
  logic             accept;
  logic             advance;

  // Result register
  logic             out_valid;
  action_e          out_action;
  logic [SEQ_W-1:0] out_seq;
  logic [SEQ_W-1:0] out_acked;
  logic [RTO_W-1:0] out_rto;

  // Advance whenever the result register is empty or being drained.
  assign advance      = s1_valid && (!out_valid || results.ready);
  assign events.ready = !s1_valid || advance;
  assign accept       = events.valid && events.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_opcode <= opcode_e'(events.opcode);
      s1_ack    <= events.ack_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Sent-time memory. Slots are indexed by the low bits of the sequence number;
  // at most MAX_WINDOW packets are in flight, so a live slot is never reused.
  // The read for an ACK is issued as its beat is accepted, and a write on the
  // same edge to the same slot is forwarded.
  // ---------------------------------------------------------------------------
  logic [TIME_BITS-1:0] send_stamps [MEM_DEPTH];
  logic                 mem_we;
  logic [MEM_AW-1:0]    mem_waddr;
  logic [MEM_AW-1:0]    mem_raddr;
  logic [SEQ_W-1:0]     ack_minus1;
  logic [TIME_BITS-1:0] rd_data;
  logic                 fwd_hit;
  logic [TIME_BITS-1:0] fwd_data;
  logic [TIME_BITS-1:0] send_stamp;

  assign ack_minus1 = events.ack_value - SEQ_W'(1);
  assign mem_raddr  = ack_minus1[MEM_AW-1:0];
  assign mem_waddr  = next_seq[MEM_AW-1:0];

  always_ff @(posedge clk) begin
    if (advance && mem_we) begin
      send_stamps[mem_waddr] <= now_ticks_next;
    end
    if (accept) begin
      rd_data  <= send_stamps[mem_raddr];
      fwd_hit  <= advance && mem_we && (mem_waddr == mem_raddr);
      fwd_data <= now_ticks_next;
    end
  end

  assign send_stamp = fwd_hit ? fwd_data : rd_data;

  // ---------------------------------------------------------------------------
  // RTT sample, saturated to 32 bits, and the estimator update
  // ---------------------------------------------------------------------------
  logic [TIME_BITS-1:0] elapsed;
  logic [63:0]          elapsed_ext;
  logic [RTO_W-1:0]     sample;
  rtt_est_t             est;

  assign elapsed     = now_ticks - send_stamp;
  assign elapsed_ext = 64'(elapsed);
  assign sample      = (elapsed_ext > 64'hFFFF_FFFF) ? '1 : elapsed_ext[RTO_W-1:0];

  sws_rtt_est u_rtt_est (
    .srtt        (smoothed_rtt),
    .dev         (rtt_deviation),
    .sample      (sample),
    .alpha_shift (alpha_shift),
    .beta_shift  (beta_shift),
    .est         (est)
  );

  // ---------------------------------------------------------------------------
  // Event processing
  // ---------------------------------------------------------------------------
  logic [WIN_W-1:0] win;
  logic [LIM_W-1:0] win_limit;
  logic             send_ok;
  logic [SQ_W-1:0]  ack_ext;
  logic [SQ_W-1:0]  total_ext;
  logic [DUP_W-1:0] dup_inc;
  action_e          action;
  logic [SQ_W-1:0]  seq_sel;
  logic [SQ_W-1:0]  acked_sel;

  // Clamp the window register to 1..MAX_WINDOW.
  always_comb begin
    if (window_size == '0) begin
      win = WIN_W'(1);
    end else if (32'(window_size) > 32'(MAX_WINDOW)) begin
      win = WIN_W'(MAX_WINDOW);
    end else begin
      win = WIN_W'(window_size);
    end
  end

  assign total_ext = SQ_W'(total_packets);
  assign ack_ext   = SQ_W'(s1_ack);
  assign win_limit = LIM_W'(send_base) + LIM_W'(win);
  assign send_ok   = (LIM_W'(next_seq) < win_limit) && (next_seq <= total_ext);
  assign dup_inc   = dup_count + DUP_W'(1);

  always_comb begin
    action             = ACT_NONE;
    seq_sel            = send_base;
    send_base_next     = send_base;
    next_seq_next      = next_seq;
    dup_count_next     = dup_count;
    smoothed_rtt_next  = smoothed_rtt;
    rtt_deviation_next = rtt_deviation;
    rto_next           = rto;
    timer_left_next    = timer_left;
    timer_on_next      = timer_on;
    now_ticks_next     = now_ticks;
    finished_next      = finished;
    mem_we             = 1'b0;

    // Once the transfer is complete every event is a no-op.
    if (!finished) begin
      if (s1_opcode == OP_TICK) begin
        now_ticks_next = now_ticks + TIME_BITS'(1);
        if (timer_on && (timer_left <= RTO_W'(1))) begin
          // Timer expired: resend the base and rearm.
          action          = ACT_TMO_RTX;
          seq_sel         = send_base;
          timer_left_next = rto;
        end else begin
          if (timer_on) begin
            timer_left_next = timer_left - RTO_W'(1);
          end
          if (send_ok) begin
            action        = ACT_SEND_NEW;
            seq_sel       = next_seq;
            mem_we        = 1'b1;
            next_seq_next = next_seq + SQ_W'(1);
            if (!timer_on) begin
              timer_on_next   = 1'b1;
              timer_left_next = rto;
            end
          end
        end
      end else begin
        if (ack_ext > next_seq) begin
          // ACK for data never sent: drop it.
          action = ACT_REJECTED;
        end else if (ack_ext > send_base) begin
          smoothed_rtt_next  = est.srtt;
          rtt_deviation_next = est.dev;
          rto_next           = est.rto;
          send_base_next     = ack_ext;
          dup_count_next     = '0;
          seq_sel            = ack_ext;
          if ((ack_ext - SQ_W'(1)) >= total_ext) begin
            finished_next   = 1'b1;
            timer_on_next   = 1'b0;
            timer_left_next = '0;
            action          = ACT_COMPLETE;
          end else begin
            action = ACT_ACKED;
            if (ack_ext == next_seq) begin
              // Nothing left in flight: stop the timer.
              timer_on_next   = 1'b0;
              timer_left_next = '0;
            end else begin
              timer_on_next   = 1'b1;
              timer_left_next = est.rto;
            end
          end
        end else if (send_base < next_seq) begin
          // Duplicate ACK with data outstanding.
          dup_count_next = dup_inc;
          if (dup_inc >= dup_threshold) begin
            action          = ACT_FAST_RTX;
            seq_sel         = send_base;
            dup_count_next  = '0;
            timer_on_next   = 1'b1;
            timer_left_next = rto;
          end
        end
      end
    end
  end

  assign acked_sel = send_base_next - SQ_W'(1);

  // ---------------------------------------------------------------------------
  // State and configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WIN_REG_W'(8);
      total_packets <= SEQ_W'(1);
      alpha_shift   <= SHIFT_W'(3);
      beta_shift    <= SHIFT_W'(2);
      dup_threshold <= DUP_W'(2);
      send_base     <= SQ_W'(1);
      next_seq      <= SQ_W'(1);
      dup_count     <= '0;
      smoothed_rtt  <= SRTT_RESET;
      rtt_deviation <= DEV_RESET;
      rto           <= RTO_RESET;
      timer_left    <= '0;
      timer_on      <= 1'b0;
      now_ticks     <= '0;
      finished      <= 1'b0;
    end else begin
      if (advance) begin
        send_base     <= send_base_next;
        next_seq      <= next_seq_next;
        dup_count     <= dup_count_next;
        smoothed_rtt  <= smoothed_rtt_next;
        rtt_deviation <= rtt_deviation_next;
        rto           <= rto_next;
        timer_left    <= timer_left_next;
        timer_on      <= timer_on_next;
        now_ticks     <= now_ticks_next;
        finished      <= finished_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_SIZE:   window_size   <= cfg_data[WIN_REG_W-1:0];
          REG_TOTAL_PACKETS: total_packets <= cfg_data[SEQ_W-1:0];
          REG_INITIAL_RTO:   rto           <= cfg_data[RTO_W-1:0];
          REG_ALPHA_SHIFT:   alpha_shift   <= cfg_data[SHIFT_W-1:0];
          REG_BETA_SHIFT:    beta_shift    <= cfg_data[SHIFT_W-1:0];
          REG_DUP_THRESHOLD: dup_threshold <= cfg_data[DUP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: hold the beat until taken, load as the next event advances.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_action <= action;
      out_seq    <= seq_sel[SEQ_W-1:0];
      out_acked  <= acked_sel[SEQ_W-1:0];
      out_rto    <= rto_next;
    end
  end

  assign results.valid         = out_valid;
  assign results.action        = out_action;
  assign results.seq_num       = out_seq;
  assign results.acked_count   = out_acked;
  assign results.timeout_value = out_rto;

endmodule
